### hw/rtl/srpg_pkg.sv
// Shared types and constants of the stepper ramp pulse generator.
// No dependencies; used by srpg_div and stepper_ramp_pulse_generator.
package srpg_pkg;

  localparam int unsigned DW = 16;           // width of counts, rates and the divider
  localparam int unsigned CW = $clog2(DW);   // divider step counter width

  localparam logic [1:0] KIND_TICK  = 2'd0;
  localparam logic [1:0] KIND_MOVE  = 2'd1;
  localparam logic [1:0] KIND_CMOVE = 2'd2;
  localparam logic [1:0] KIND_ZERO  = 2'd3;

  localparam logic [DW-1:0] TPS_RESET = 16'd2000;

  // input beat payload, s_tdata, highest bit first
  typedef struct packed {
    logic [5:0]  pad;
    logic        condition_level;
    logic [7:0]  start_rate;
    logic [15:0] ramp_length;
    logic [15:0] move_rate;
    logic        move_dir;
    logic [15:0] move_steps;
  } in_data_t;

  // output beat payload, m_tdata, highest bit first
  typedef struct packed {
    logic [3:0]  pad;
    logic        in_condition_mode;
    logic [15:0] steps_taken;
    logic        command_done;
    logic        dir_level;
    logic        pulse_level;
  } out_data_t;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_DIV1 = 4'b0010,
    S_DIV2 = 4'b0100,
    S_EMIT = 4'b1000
  } state_t;

endpackage

### hw/rtl/srpg_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on srpg_pkg for the data width; divisor must be nonzero.
module srpg_div (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [srpg_pkg::DW-1:0] dividend,
  input  logic [srpg_pkg::DW-1:0] divisor,
  output logic                  done,
  output logic [srpg_pkg::DW-1:0] quotient
);

  logic                    busy;
  logic [srpg_pkg::CW-1:0] cnt;
  logic [srpg_pkg::DW-1:0] rem;
  logic [srpg_pkg::DW-1:0] quo;
  logic [srpg_pkg::DW-1:0] dvs;
  logic [srpg_pkg::DW:0]   rem_sh;
  logic [srpg_pkg::DW:0]   trial;
  logic                    fits;

  // shift the next dividend bit into the partial remainder and try a subtract
  assign rem_sh   = {rem, quo[srpg_pkg::DW-1]};
  assign trial    = rem_sh - {1'b0, dvs};
  assign fits     = (rem_sh >= {1'b0, dvs});
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == srpg_pkg::CW'(srpg_pkg::DW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      rem <= fits ? trial[srpg_pkg::DW-1:0] : rem_sh[srpg_pkg::DW-1:0];
      quo <= {quo[srpg_pkg::DW-2:0], fits};
    end
  end

endmodule

### hw/rtl/stepper_ramp_pulse_generator.sv
// Top level of the stepper ramp pulse generator: command decode, tick timing, ramp.
// Depends on srpg_pkg and srpg_div.
//
// Usage: every input beat on s_* is a tick or a command (selected by s_tuser) and
// yields exactly one output beat on m_* with the step and direction line levels,
// the command done flag, the step position and the mode.
// A command (step move, condition move, zero) goes from S_IDLE straight to S_EMIT,
// which writes its result to the output register; the next beat is taken in S_IDLE.
// A tick runs ticks_per_second / rate through the bit-serial divider in S_DIV1, and
// S_EMIT then writes its result. When a step with an active ramp is issued, the ramp
// increment target_rate / ramp_length reuses the divider in S_DIV2 before S_EMIT.
// Items are processed one at a time. The result lands in an output register; the
// next input beat is taken while it waits, and a stalled m_tready holds back the
// write of the following result, which keeps the block in S_EMIT and s_tready low.
// cfg_* writes ticks_per_second; it is always ready and is to be written while idle.
// Reset (rst, synchronous) restores all state: rate 1, direction clockwise,
// position zero, ticks_per_second 2000, and an empty output register.
module stepper_ramp_pulse_generator (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // move_steps, move_dir, move_rate, ramp_length,
                                 // start_rate, condition_level, zero pad
  input  logic [1:0]  s_tuser,   // kind
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // pulse_level, dir_level, command_done,
                                 // steps_taken, in_condition_mode, zero pad
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  srpg_pkg::state_t   state;
  srpg_pkg::in_data_t din;
  srpg_pkg::out_data_t dout;

  logic [15:0] tps;
  logic        mode_cond;
  logic [15:0] tick_count;
  logic [15:0] step_pos;
  logic [15:0] step_goal;
  logic [15:0] target_rate;
  logic [15:0] present_rate;
  logic [15:0] ramp_steps_held;
  logic [7:0]  ramp_floor;
  logic        dir_held;
  logic        cond_reached;
  logic        pulse_held;
  logic        dir_line;
  logic        done_flag;
  logic        done_next;
  logic        cond_lat;

  logic        in_beat;
  logic        div_start;
  logic [15:0] div_dividend;
  logic [15:0] div_divisor;
  logic        div_done;
  logic [15:0] div_q;
  logic [15:0] rate_sel;

  logic [7:0]         delta;
  logic signed [17:0] diff_up;
  logic signed [17:0] diff_dn;
  logic signed [17:0] goal_less_ramp;
  logic signed [17:0] delta_s;

  assign din       = srpg_pkg::in_data_t'(s_tdata);
  assign s_tready  = (state == srpg_pkg::S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_beat   = s_tvalid && s_tready;

  assign rate_sel = mode_cond ? target_rate : present_rate;

  // first division sets the period, second one the ramp increment
  always_comb begin
    div_start    = 1'b0;
    div_dividend = tps;
    div_divisor  = (rate_sel == 16'd0) ? 16'd1 : rate_sel;
    if (state == srpg_pkg::S_IDLE) begin
      div_start = in_beat && (s_tuser == srpg_pkg::KIND_TICK);
    end else begin
      div_dividend = target_rate;
      div_divisor  = ramp_steps_held;
      div_start    = (state == srpg_pkg::S_DIV1) && div_done && (tick_count >= div_q) &&
                     !mode_cond && (step_goal > step_pos) && (ramp_steps_held != 16'd0);
    end
  end

  // done flag of the command in the current input beat
  always_comb begin
    unique case (s_tuser)
      srpg_pkg::KIND_MOVE: begin
        done_next = !(step_pos == 16'd0 && din.move_steps != 16'd0) &&
                    (step_pos == step_goal || din.move_steps == 16'd0);
      end
      srpg_pkg::KIND_CMOVE: done_next = din.condition_level && cond_reached;
      srpg_pkg::KIND_ZERO:  done_next = 1'b1;
      default:              done_next = 1'b0;
    endcase
  end

  srpg_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  assign delta          = div_q[7:0];
  assign delta_s        = $signed({10'd0, delta});
  assign diff_up        = $signed({2'b00, target_rate}) - $signed({2'b00, present_rate});
  assign diff_dn        = $signed({2'b00, present_rate}) - $signed({10'd0, ramp_floor});
  assign goal_less_ramp = $signed({2'b00, step_goal}) - $signed({2'b00, ramp_steps_held});

  always_comb begin
    dout                   = '0;
    dout.pulse_level       = pulse_held;
    dout.dir_level         = dir_line;
    dout.command_done      = done_flag;
    dout.steps_taken       = step_pos;
    dout.in_condition_mode = mode_cond;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= srpg_pkg::S_IDLE;
      tps             <= srpg_pkg::TPS_RESET;
      mode_cond       <= 1'b0;
      tick_count      <= '0;
      step_pos        <= '0;
      step_goal       <= '0;
      target_rate     <= 16'd1;
      present_rate    <= 16'd1;
      ramp_steps_held <= '0;
      ramp_floor      <= '0;
      dir_held        <= 1'b1;
      cond_reached    <= 1'b1;
      pulse_held      <= 1'b0;
      dir_line        <= 1'b1;
      done_flag       <= 1'b0;
      cond_lat        <= 1'b0;
      m_tvalid        <= 1'b0;
    end else begin
      if (cfg_valid) begin
        tps <= cfg_data;
      end
      if (state == srpg_pkg::S_EMIT && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      unique case (state)
        srpg_pkg::S_IDLE: begin
          if (in_beat) begin
            done_flag <= done_next;
            cond_lat  <= din.condition_level;
            state     <= (s_tuser == srpg_pkg::KIND_TICK) ? srpg_pkg::S_DIV1
                                                          : srpg_pkg::S_EMIT;
            unique case (s_tuser)
              srpg_pkg::KIND_TICK: ;
              srpg_pkg::KIND_MOVE: begin
                if (step_pos == 16'd0 && din.move_steps != 16'd0) begin
                  step_goal       <= din.move_steps;
                  target_rate     <= din.move_rate;
                  ramp_floor      <= din.start_rate;
                  present_rate    <= (din.ramp_length == 16'd0) ? din.move_rate
                                                                : {8'd0, din.start_rate};
                  dir_held        <= din.move_dir;
                  mode_cond       <= 1'b0;
                  ramp_steps_held <= din.ramp_length;
                  cond_reached    <= 1'b1;
                end
              end
              srpg_pkg::KIND_CMOVE: begin
                if (!din.condition_level) begin
                  target_rate  <= din.move_rate;
                  dir_held     <= din.move_dir;
                  mode_cond    <= 1'b1;
                  cond_reached <= 1'b0;
                end else if (cond_reached) begin
                  cond_reached <= 1'b0;
                end
              end
              srpg_pkg::KIND_ZERO: begin
                step_pos  <= '0;
                step_goal <= '0;
              end
              default: ;
            endcase
          end
        end

        srpg_pkg::S_DIV1: begin
          if (div_done) begin
            // a ramped step goes on to the second division
            state <= div_start ? srpg_pkg::S_DIV2 : srpg_pkg::S_EMIT;
            if (tick_count >= div_q) begin
              // period expired
              dir_line   <= dir_held;
              tick_count <= '0;
              if (mode_cond) begin
                if (!cond_lat) begin
                  pulse_held <= 1'b1;
                end else begin
                  cond_reached <= 1'b1;
                  mode_cond    <= 1'b0;
                end
              end else if (step_goal > step_pos) begin
                if (ramp_steps_held == 16'd0) begin
                  pulse_held <= 1'b1;
                  step_pos   <= step_pos + 16'd1;
                end
              end else begin
                present_rate <= target_rate;
              end
            end else begin
              pulse_held <= 1'b0;
              tick_count <= tick_count + 16'd1;
            end
          end
        end

        srpg_pkg::S_DIV2: begin
          if (div_done) begin
            if (delta != 8'd0) begin
              if (step_pos < ramp_steps_held) begin
                present_rate <= (diff_up < delta_s) ? target_rate
                                                    : present_rate + {8'd0, delta};
              end else if (goal_less_ramp < $signed({2'b00, step_pos})) begin
                present_rate <= (diff_dn < delta_s) ? {8'd0, ramp_floor}
                                                    : present_rate - {8'd0, delta};
              end
            end
            pulse_held <= 1'b1;
            step_pos   <= step_pos + 16'd1;
            state      <= srpg_pkg::S_EMIT;
          end
        end

        srpg_pkg::S_EMIT: begin
          // hold the result until the output register is free
          if (!m_tvalid || m_tready) begin
            state <= srpg_pkg::S_IDLE;
          end
        end

        default: state <= srpg_pkg::S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == srpg_pkg::S_EMIT && (!m_tvalid || m_tready)) begin
      m_tdata <= dout;
    end
  end

endmodule

### test/tb.sv
// Self-checking testbench for stepper_ramp_pulse_generator: directed and random beats,
// with a scoreboard class that predicts every output beat.
// Depends on srpg_pkg and the RTL of the block.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 800000;
  localparam int SEG_BEATS   = 325;
  localparam int HOLD_CYCLES = 400;

  // Predicts step/dir line levels, done flags, step position and mode, holds them until the block answers.
  class ramp_scoreboard;
    logic [15:0] tps;
    logic [15:0] tick_count, step_pos, step_goal;
    logic [15:0] target_rate, present_rate, ramp_held;
    logic [7:0]  ramp_floor;
    logic        mode_cond, dir_held, cond_reached, pulse_held, dir_line;
    srpg_pkg::out_data_t expected_lines[$];
    int          errors;
    int          checked;

    function new();
      tps          = srpg_pkg::TPS_RESET;
      tick_count   = '0;
      step_pos     = '0;
      step_goal    = '0;
      target_rate  = 16'd1;
      present_rate = 16'd1;
      ramp_held    = '0;
      ramp_floor   = '0;
      mode_cond    = 1'b0;
      dir_held     = 1'b1;
      cond_reached = 1'b1;
      pulse_held   = 1'b0;
      dir_line     = 1'b1;
      errors       = 0;
      checked      = 0;
    endfunction

    function int pending();
      return expected_lines.size();
    endfunction

    function void apply_ramp();
      int delta;
      int diff;
      delta = 0;
      if (ramp_held != 16'd0) delta = (int'(target_rate) / int'(ramp_held)) & 'hFF;
      if (delta == 0) return;
      if (step_pos < ramp_held) begin
        diff = int'(target_rate) - int'(present_rate);
        if (diff < delta) present_rate = target_rate;
        else present_rate = present_rate + 16'(delta);
      end else if (int'(step_goal) - int'(ramp_held) < int'(step_pos)) begin
        diff = int'(present_rate) - int'(ramp_floor);
        if (diff < delta) present_rate = {8'd0, ramp_floor};
        else present_rate = present_rate - 16'(delta);
      end
    endfunction

    function void advance_tick(logic cond);
      logic [15:0] rate;
      int          period;
      rate   = mode_cond ? target_rate : present_rate;
      period = int'(tps) / ((rate == 16'd0) ? 1 : int'(rate));
      if (int'(tick_count) >= period) begin
        dir_line = dir_held;
        if (mode_cond) begin
          if (!cond) begin
            pulse_held = 1'b1;
          end else begin
            cond_reached = 1'b1;
            mode_cond    = 1'b0;
          end
        end else if (step_goal > step_pos) begin
          apply_ramp();
          pulse_held = 1'b1;
          step_pos   = step_pos + 16'd1;
        end else begin
          present_rate = target_rate;
        end
        tick_count = '0;
      end else begin
        pulse_held = 1'b0;
        tick_count = tick_count + 16'd1;
      end
    endfunction

    function void note_beat(logic [1:0] kind, srpg_pkg::in_data_t d);
      logic                done;
      srpg_pkg::out_data_t e;
      done = 1'b0;
      case (kind)
        srpg_pkg::KIND_TICK: advance_tick(d.condition_level);
        srpg_pkg::KIND_MOVE: begin
          if (step_pos == 16'd0 && d.move_steps != 16'd0) begin
            step_goal    = d.move_steps;
            target_rate  = d.move_rate;
            ramp_floor   = d.start_rate;
            present_rate = (d.ramp_length == 16'd0) ? d.move_rate : {8'd0, d.start_rate};
            dir_held     = d.move_dir;
            mode_cond    = 1'b0;
            ramp_held    = d.ramp_length;
            cond_reached = 1'b1;
          end else if (step_pos == step_goal || d.move_steps == 16'd0) begin
            done = 1'b1;
          end
        end
        srpg_pkg::KIND_CMOVE: begin
          if (!d.condition_level) begin
            target_rate  = d.move_rate;
            dir_held     = d.move_dir;
            mode_cond    = 1'b1;
            cond_reached = 1'b0;
          end else if (cond_reached) begin
            cond_reached = 1'b0;
            done         = 1'b1;
          end
        end
        default: begin
          step_pos  = '0;
          step_goal = '0;
          done      = 1'b1;
        end
      endcase
      e                   = '0;
      e.pulse_level       = pulse_held;
      e.dir_level         = dir_line;
      e.command_done      = done;
      e.steps_taken       = step_pos;
      e.in_condition_mode = mode_cond;
      expected_lines.push_back(e);
    endfunction

    function void field_ok(string name, int unsigned exp_v, int unsigned got_v);
      if (exp_v != got_v) begin
        errors++;
        $display("%0t mismatch %s: expected %0d actual %0d", $time, name, exp_v, got_v);
      end
    endfunction

    function void check_beat(srpg_pkg::out_data_t got);
      srpg_pkg::out_data_t e;
      if (expected_lines.size() == 0) begin
        errors++;
        $display("%0t unexpected output beat: expected none actual %h", $time, got);
        return;
      end
      e = expected_lines.pop_front();
      checked++;
      field_ok("pulse_level", 32'(e.pulse_level), 32'(got.pulse_level));
      field_ok("dir_level", 32'(e.dir_level), 32'(got.dir_level));
      field_ok("command_done", 32'(e.command_done), 32'(got.command_done));
      field_ok("steps_taken", 32'(e.steps_taken), 32'(got.steps_taken));
      field_ok("in_condition_mode", 32'(e.in_condition_mode), 32'(got.in_condition_mode));
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [63:0] s_tdata;
  logic [1:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [23:0] m_tdata;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [15:0] cfg_data;

  ramp_scoreboard sb = new();

  int          send_idle;
  int          recv_idle;
  logic        hold_toggle = 1'b0;
  int          cycle_count;
  int          total_beats;
  int          random_beats;
  logic [15:0] cur_tps;

  stepper_ramp_pulse_generator DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d beats still expected", cycle_count, sb.pending());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Receiver: check accepted beats, stall at random or for a requested long hold.
  initial begin : receiver
    int   hold_left;
    logic seen_toggle;
    hold_left   = 0;
    seen_toggle = 1'b0;
    m_tready    = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) sb.check_beat(srpg_pkg::out_data_t'(m_tdata));
      if (hold_toggle != seen_toggle) begin
        hold_left   = HOLD_CYCLES;
        seen_toggle = hold_toggle;
      end
      if (hold_left > 0) begin
        m_tready <= 1'b0;
        hold_left--;
      end else begin
        m_tready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  function automatic srpg_pkg::in_data_t rand_fields();
    srpg_pkg::in_data_t d;
    d                 = '0;
    d.move_steps      = 16'($urandom_range(65535));
    d.move_dir        = 1'($urandom_range(1));
    d.move_rate       = 16'($urandom_range(65535));
    d.ramp_length     = 16'($urandom_range(65535));
    d.start_rate      = 8'($urandom_range(255));
    d.condition_level = 1'($urandom_range(1));
    return d;
  endfunction

  // Rates mostly give short periods at the present tick rate, sometimes anything.
  function automatic logic [15:0] pick_rate();
    int unsigned r;
    case ($urandom_range(9))
      0: r = $urandom_range(65535);
      1: r = 0;
      2: r = 65535;
      default: begin
        r = cur_tps / $urandom_range(1, 6);
        if (r == 0) r = $urandom_range(1, 3);
      end
    endcase
    return 16'(r);
  endfunction

  function automatic logic [7:0] pick_start();
    int unsigned s;
    if ($urandom_range(3) == 0) return 8'($urandom_range(255));
    s = cur_tps / $urandom_range(1, 12);
    if (s > 255) s = 255;
    return 8'(s);
  endfunction

  // Hold valid high between back-to-back beats; drop it only for random idle cycles.
  task automatic send_item(input logic [1:0] kind, input srpg_pkg::in_data_t d);
    while (send_idle > 0 && $urandom_range(99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= d;
    do @(posedge clk); while (!s_tready);
    sb.note_beat(kind, d);
    total_beats++;
    random_beats++;
  endtask

  task automatic send_fields(input logic [1:0] kind, input logic [15:0] steps, input logic dir,
                             input logic [15:0] rate, input logic [15:0] ramp,
                             input logic [7:0] start, input logic cond);
    srpg_pkg::in_data_t d;
    d                 = '0;
    d.move_steps      = steps;
    d.move_dir        = dir;
    d.move_rate       = rate;
    d.ramp_length     = ramp;
    d.start_rate      = start;
    d.condition_level = cond;
    send_item(kind, d);
  endtask

  task automatic send_tick(input logic cond);
    srpg_pkg::in_data_t d;
    d                 = rand_fields();
    d.condition_level = cond;
    send_item(srpg_pkg::KIND_TICK, d);
  endtask

  task automatic drain_block();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_tps(input logic [15:0] v);
    cfg_data  <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.tps  = v;
    cur_tps = v;
  endtask

  task automatic step_move_run();
    srpg_pkg::in_data_t d;
    logic [15:0]        steps;
    int                 n;
    send_item(srpg_pkg::KIND_ZERO, rand_fields());
    d       = rand_fields();
    steps   = ($urandom_range(19) == 0) ? 16'($urandom_range(65535))
                                        : 16'($urandom_range(1, 24));
    d.move_steps = steps;
    d.move_rate  = pick_rate();
    d.start_rate = pick_start();
    if ($urandom_range(9) < ((cur_tps > 16'd2040) ? 7 : 3)) d.ramp_length = '0;
    else if ($urandom_range(9) == 0) d.ramp_length = 16'($urandom_range(65535));
    else d.ramp_length = 16'($urandom_range(0, int'(steps) + 2));
    send_item(srpg_pkg::KIND_MOVE, d);
    n = 0;
    while (sb.step_pos != sb.step_goal && n < 60) begin
      if ($urandom_range(29) == 0)
        send_item($urandom_range(1) ? srpg_pkg::KIND_MOVE : srpg_pkg::KIND_CMOVE,
                  rand_fields());
      else send_tick(1'($urandom_range(1)));
      n++;
    end
    repeat ($urandom_range(0, 3)) send_tick(1'($urandom_range(1)));
    d = rand_fields();
    if ($urandom_range(7) != 0 && d.move_steps == 16'd0) d.move_steps = 16'd1;
    send_item(srpg_pkg::KIND_MOVE, d);
  endtask

  task automatic cond_move_run();
    srpg_pkg::in_data_t d;
    int                 n;
    d                 = rand_fields();
    d.condition_level = 1'b0;
    d.move_rate       = pick_rate();
    send_item(srpg_pkg::KIND_CMOVE, d);
    repeat ($urandom_range(1, 12)) send_tick(1'b0);
    n = 0;
    while (sb.mode_cond && n < 60) begin
      send_tick(1'b1);
      n++;
    end
    d                 = rand_fields();
    d.condition_level = 1'b1;
    send_item(srpg_pkg::KIND_CMOVE, d);
  endtask

  initial begin : stimulus
    int          seg;
    int          pick;
    logic [15:0] tps_plan[6];
    rst          = 1'b1;
    s_tvalid     = 1'b0;
    s_tdata      = '0;
    s_tuser      = srpg_pkg::KIND_TICK;
    cfg_valid    = 1'b0;
    cfg_data     = '0;
    send_idle    = 7;
    recv_idle    = 54;
    total_beats  = 0;
    random_beats = 0;
    cur_tps      = srpg_pkg::TPS_RESET;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part at the reset tick rate.
    send_fields(srpg_pkg::KIND_TICK, 16'd0, 1'b0, 16'd0, 16'd0, 8'd0, 1'b0);
    send_fields(srpg_pkg::KIND_MOVE, 16'd0, 1'b0, 16'd0, 16'd0, 8'd0, 1'b0);  // zero steps
    send_fields(srpg_pkg::KIND_CMOVE, 16'd0, 1'b0, 16'd0, 16'd0, 8'd0, 1'b1); // flag at reset
    send_fields(srpg_pkg::KIND_CMOVE, 16'd0, 1'b0, 16'd0, 16'd0, 8'd0, 1'b1); // flag cleared
    send_fields(srpg_pkg::KIND_MOVE, 16'd3, 1'b0, 16'hFFFF, 16'd0, 8'd255, 1'b0); // period 0
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b0);                                                     // finished: rate reload
    send_fields(srpg_pkg::KIND_MOVE, 16'hFFFF, 1'b1, 16'hFFFF, 16'hFFFF, 8'd255, 1'b1);
    send_fields(srpg_pkg::KIND_ZERO, 16'hFFFF, 1'b1, 16'hFFFF, 16'hFFFF, 8'd255, 1'b1);
    send_fields(srpg_pkg::KIND_MOVE, 16'hFFFF, 1'b1, 16'hFFFF, 16'hFFFF, 8'd255, 1'b1);
    repeat (9) send_tick(1'b0);                                          // first ramp step
    send_fields(srpg_pkg::KIND_MOVE, 16'd5, 1'b0, 16'd100, 16'd2, 8'd10, 1'b0); // busy
    send_fields(srpg_pkg::KIND_CMOVE, 16'd0, 1'b0, 16'd0, 16'd0, 8'd0, 1'b0);   // zero rate
    send_tick(1'b0);
    send_fields(srpg_pkg::KIND_CMOVE, 16'd0, 1'b1, 16'hFFFF, 16'd0, 8'd0, 1'b0); // reload
    send_tick(1'b0);
    send_tick(1'b1);
    send_fields(srpg_pkg::KIND_CMOVE, 16'd0, 1'b1, 16'd0, 16'd0, 8'd0, 1'b1);
    send_fields(srpg_pkg::KIND_ZERO, 16'd0, 1'b0, 16'd0, 16'd0, 8'd0, 1'b0);

    tps_plan[0] = 16'd1;
    tps_plan[1] = 16'd2000;
    tps_plan[2] = 16'hFFFF;
    tps_plan[3] = 16'($urandom_range(1, 65535));
    tps_plan[4] = 16'd300;
    tps_plan[5] = 16'($urandom_range(1, 4000));
    random_beats = 0;
    for (seg = 0; seg < 6; seg++) begin
      drain_block();
      write_tps(tps_plan[seg]);
      send_idle = (seg < 2) ? 7 : (seg < 4) ? 54 : 0;
      recv_idle = (seg < 2) ? 54 : (seg < 4) ? 7 : 0;
      if (seg == 0) hold_toggle = !hold_toggle;   // fill the block and stall its input
      while (random_beats < (seg + 1) * SEG_BEATS) begin
        pick = $urandom_range(99);
        if (pick < 55) step_move_run();
        else if (pick < 82) cond_move_run();
        else repeat ($urandom_range(1, 4)) send_item(2'($urandom_range(3)), rand_fields());
      end
    end

    drain_block();
    if (sb.pending() != 0)
      $display("%0t %0d expected beats never arrived", $time, sb.pending());
    $display("Covered %0d beats: directed extremes, ramped and flat step moves,", total_beats);
    $display("condition moves and noise under several tick rates; %0d output beats compared",
             sb.checked);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
